>>> rtl/terq_pkg.sv
// Shared constants, codes and types of the timed event release queue.
package terq_pkg;

  localparam int unsigned QueueDepthDefault = 32;

  localparam logic [23:0] MsPerSampleReset = 24'd1486;
  localparam logic [9:0]  LookaheadReset   = 10'd20;
  localparam logic [15:0] LateLimitReset   = 16'd200;
  localparam logic [15:0] IdleWaitReset    = 16'd500;

  localparam int unsigned TimeW    = 48;
  localparam int unsigned PayloadW = 26;

  localparam logic [1:0] ReqInsert = 2'd0;
  localparam logic [1:0] ReqTick   = 2'd1;
  localparam logic [1:0] ReqClear  = 2'd2;

  localparam logic [2:0] KindInserted = 3'd0;
  localparam logic [2:0] KindFull     = 3'd1;
  localparam logic [2:0] KindReleased = 3'd2;
  localparam logic [2:0] KindDropped  = 3'd3;
  localparam logic [2:0] KindNotDue   = 3'd4;
  localparam logic [2:0] KindCleared  = 3'd5;

  localparam logic [1:0] CfgMsPerSample = 2'd0;
  localparam logic [1:0] CfgLookahead   = 2'd1;
  localparam logic [1:0] CfgLateLimit   = 2'd2;
  localparam logic [1:0] CfgIdleWait    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request and start the time product
    logic calc;       // form the insert time from the product
    logic rd_issue;   // read the memory at the walk address
    logic rd_check;   // compare the read entry and step the walk
    logic wr_insert;  // write the new entry at the walk address
    logic mv_issue;   // read the entry for a shift
    logic mv_write;   // write the shifted entry
    logic head_eval;  // evaluate the head for a tick
    logic finish;     // latch the result item
    logic clear;      // empty the queue
  } terq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req;
    logic       full;
    logic       empty;
    logic       walk_done;
    logic       found;
    logic       move_done;
    logic       head_due;
  } terq_stat_t;

endpackage

>>> rtl/terq_ctrl.sv
// Controller state machine of the timed event release queue.
module terq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  logic                out_fire_i,
  input  terq_pkg::terq_stat_t stat_i,
  output terq_pkg::terq_cmd_t  cmd_o,
  output logic                in_ready_o,
  output logic                out_valid_o
);

  typedef enum logic [3:0] {
    StIdle, StCalc, StDecide, StRdIssue, StRdWait, StRdCheck,
    StShIssue, StShWait, StShWrite, StInsert, StHeadIssue, StHeadWait,
    StPopIssue, StPopWait, StPopWrite, StOut
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    cmd_o   = '0;
    if (out_fire_i) begin
      valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_d = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d = StDecide;
      end
      StDecide: begin
        if (!valid_q || out_fire_i) begin
          case (stat_i.req)
            terq_pkg::ReqInsert: begin
              if (stat_i.full) begin
                state_d = StOut;
              end else begin
                state_d = StRdIssue;
              end
            end
            terq_pkg::ReqTick: begin
              if (stat_i.empty) begin
                state_d = StOut;
              end else begin
                state_d = StHeadIssue;
              end
            end
            terq_pkg::ReqClear: begin
              cmd_o.clear = 1'b1;
              state_d = StOut;
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StRdIssue: begin
        if (stat_i.walk_done) begin
          state_d = StShIssue;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d = StRdWait;
        end
      end
      StRdWait: state_d = StRdCheck;
      StRdCheck: begin
        cmd_o.rd_check = 1'b1;
        if (stat_i.found) begin
          state_d = StShIssue;
        end else begin
          state_d = StRdIssue;
        end
      end
      StShIssue: begin
        if (stat_i.move_done) begin
          state_d = StInsert;
        end else begin
          cmd_o.mv_issue = 1'b1;
          state_d = StShWait;
        end
      end
      StShWait: state_d = StShWrite;
      StShWrite: begin
        cmd_o.mv_write = 1'b1;
        state_d = StShIssue;
      end
      StInsert: begin
        cmd_o.wr_insert = 1'b1;
        state_d = StOut;
      end
      StHeadIssue: begin
        cmd_o.rd_issue = 1'b1;
        state_d = StHeadWait;
      end
      StHeadWait: begin
        cmd_o.head_eval = 1'b1;
        if (stat_i.head_due) begin
          state_d = StPopIssue;
        end else begin
          state_d = StOut;
        end
      end
      StPopIssue: begin
        if (stat_i.move_done) begin
          state_d = StOut;
        end else begin
          cmd_o.mv_issue = 1'b1;
          state_d = StPopWait;
        end
      end
      StPopWait: state_d = StPopWrite;
      StPopWrite: begin
        cmd_o.mv_write = 1'b1;
        state_d = StPopIssue;
      end
      StOut: begin
        cmd_o.finish = 1'b1;
        valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = valid_q;

endmodule

>>> rtl/terq_datapath.sv
// Datapath of the timed event release queue: entry memory, walk and arithmetic.
module terq_datapath #(
  parameter int unsigned QueueDepth = terq_pkg::QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  terq_pkg::terq_cmd_t  cmd_i,
  output terq_pkg::terq_stat_t stat_o,
  input  logic [1:0]           req_type_i,
  input  logic [31:0]          block_start_ms_i,
  input  logic [15:0]          sample_offset_i,
  input  logic [23:0]          msg_bytes_i,
  input  logic [1:0]           msg_len_i,
  input  logic [31:0]          now_ms_i,
  input  logic [23:0]          ms_per_sample_i,
  input  logic [9:0]           lookahead_i,
  input  logic [15:0]          late_limit_i,
  input  logic [15:0]          idle_wait_i,
  output logic [2:0]           result_kind_o,
  output logic [23:0]          out_bytes_o,
  output logic [1:0]           out_len_o,
  output logic [31:0]          release_ms_o,
  output logic [31:0]          wait_ms_o,
  output logic [5:0]           queue_count_o
);

  localparam int unsigned AddrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CountW = $clog2(QueueDepth + 1);
  localparam int unsigned EntryW = terq_pkg::TimeW + terq_pkg::PayloadW;
  localparam int unsigned TimeW  = terq_pkg::TimeW;

  logic [EntryW-1:0] mem_q [QueueDepth];
  logic [EntryW-1:0] rd_q;

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] walk_q;
  logic [CountW-1:0] mv_q;
  logic              pop_q;
  logic              rej_q;
  logic [1:0]        req_q;
  logic [31:0]       start_q;
  logic [39:0]       prod_q;
  logic [31:0]       now_q;
  logic [terq_pkg::PayloadW-1:0] pay_q;
  logic [TimeW-1:0]  t_q;
  logic [32:0]       limit_q;
  logic [32:0]       rel_q;
  logic [2:0]        kind_q;
  logic [terq_pkg::PayloadW-1:0] opay_q;
  logic [31:0]       orel_q;
  logic [31:0]       owait_q;

  logic [48:0] t_sum;
  logic [32:0] rel_w;
  logic [32:0] rel_sat;
  logic [33:0] late_sum;
  logic        found_w;

  assign t_sum   = {1'b0, start_q, 16'd0} + {9'd0, prod_q};
  assign rel_w   = {1'b0, rd_q[EntryW-1 -: 32]} +
                   {32'd0, rd_q[terq_pkg::PayloadW + 15]};
  assign rel_sat = rel_w[32] ? {1'b0, 32'hFFFF_FFFF} : rel_w;
  assign late_sum = {1'b0, rel_q} + {18'd0, late_limit_i};
  assign found_w  = rd_q[EntryW-1 -: TimeW] > t_q;

  assign stat_o.req       = req_q;
  assign stat_o.full      = (count_q >= CountW'(QueueDepth));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.walk_done = (walk_q == count_q);
  assign stat_o.found     = found_w;
  assign stat_o.move_done = pop_q ? (mv_q + CountW'(1) >= count_q)
                                  : (mv_q == walk_q);
  assign stat_o.head_due  = (rel_sat <= limit_q);

  // Memory port: one read and one write address per cycle.
  logic [AddrW-1:0] rd_addr;
  always_comb begin
    if (cmd_i.mv_issue) begin
      rd_addr = pop_q ? AddrW'(mv_q + CountW'(1)) : AddrW'(mv_q - CountW'(1));
    end else begin
      rd_addr = AddrW'(walk_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue || cmd_i.mv_issue) begin
      rd_q <= mem_q[rd_addr];
    end
    if (cmd_i.mv_write) begin
      mem_q[AddrW'(mv_q)] <= rd_q;
    end else if (cmd_i.wr_insert) begin
      mem_q[AddrW'(walk_q)] <= {t_q, pay_q};
    end
  end

  // The result registers are only written after the previous result has
  // been taken, so a waiting result stays unchanged.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q <= block_start_ms_i;
      prod_q  <= {24'd0, sample_offset_i} * {16'd0, ms_per_sample_i};
      now_q   <= now_ms_i;
      pay_q   <= {msg_len_i, msg_bytes_i};
    end
    if (cmd_i.calc) begin
      t_q     <= t_sum[48] ? {TimeW{1'b1}} : t_sum[TimeW-1:0];
      limit_q <= {1'b0, now_q} + {23'd0, lookahead_i};
      rej_q   <= stat_o.full;
    end
    if (cmd_i.head_eval) begin
      rel_q  <= rel_sat;
      opay_q <= rd_q[terq_pkg::PayloadW-1:0];
      if (rel_sat > limit_q) begin
        owait_q <= 32'(rel_sat - limit_q);
      end
    end
    if (cmd_i.finish) begin
      case (req_q)
        terq_pkg::ReqInsert: begin
          kind_q  <= rej_q ? terq_pkg::KindFull : terq_pkg::KindInserted;
          opay_q  <= '0;
          orel_q  <= '0;
          owait_q <= '0;
        end
        terq_pkg::ReqTick: begin
          if (pop_q) begin
            kind_q  <= (late_sum > {2'b0, now_q}) ? terq_pkg::KindReleased
                                                   : terq_pkg::KindDropped;
            orel_q  <= rel_q[31:0];
            owait_q <= '0;
          end else if (stat_o.empty) begin
            kind_q  <= terq_pkg::KindNotDue;
            owait_q <= {16'd0, idle_wait_i};
            opay_q  <= '0;
            orel_q  <= '0;
          end else begin
            kind_q <= terq_pkg::KindNotDue;
            opay_q <= '0;
            orel_q <= '0;
          end
        end
        default: begin
          kind_q  <= terq_pkg::KindCleared;
          opay_q  <= '0;
          orel_q  <= '0;
          owait_q <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      walk_q  <= '0;
      mv_q    <= '0;
      pop_q   <= 1'b0;
      req_q   <= terq_pkg::ReqInsert;
    end else begin
      if (cmd_i.load) begin
        req_q  <= req_type_i;
        walk_q <= '0;
        pop_q  <= 1'b0;
        mv_q   <= count_q;
      end
      if (cmd_i.rd_check && !found_w) begin
        walk_q <= walk_q + CountW'(1);
      end
      if (cmd_i.head_eval && (rel_sat <= limit_q)) begin
        pop_q <= 1'b1;
        mv_q  <= '0;
      end
      if (cmd_i.mv_write) begin
        mv_q <= pop_q ? mv_q + CountW'(1) : mv_q - CountW'(1);
      end
      if (cmd_i.wr_insert) begin
        count_q <= count_q + CountW'(1);
      end
      if (cmd_i.mv_issue == 1'b0 && pop_q && stat_o.move_done && cmd_i.finish) begin
        count_q <= count_q - CountW'(1);
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end
    end
  end

  assign result_kind_o = kind_q;
  assign out_bytes_o   = opay_q[23:0];
  assign out_len_o     = opay_q[25:24];
  assign release_ms_o  = orel_q;
  assign wait_ms_o     = owait_q;
  assign queue_count_o = 6'(count_q);

endmodule

>>> rtl/timed_event_release_queue.sv
// Top level of the timed event release queue.
// This block keeps up to QUEUE_DEPTH short messages sorted by release time
// in Q16 milliseconds, with equal times kept in arrival order. Each input item
// is an insert, a tick or a clear, selected by tuser, and each yields exactly
// one result item whose kind travels in tuser; an unknown request is dropped
// without a result. An item is handled by a controller that steps one memory
// port. An insert walks the held entries until it finds the first later one
// and then shifts the later ones up before it writes the new entry. A tick
// that pops shifts the remaining entries down; a tick that pops nothing only
// reads the head, and a clear, a rejected insert or a tick on an empty queue
// goes straight to its result. The entry memory needs no clearing pass after
// reset. The finished result waits in an output register; the next item is
// taken right away, but after its load and calc states it holds until the
// waiting result has been accepted.
module timed_event_release_queue #(
  parameter int unsigned QUEUE_DEPTH = terq_pkg::QueueDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // low bit up: block_start_ms[31:0], sample_offset[47:32], msg_bytes[71:48],
  // msg_len[73:72], now_ms[105:74], zero fill to 112
  input  logic [111:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // low bit up: out_bytes[23:0], out_len[25:24], release_ms[57:26],
  // wait_ms[89:58], queue_count[95:90]
  output logic [95:0]  m_axis_tdata,
  // result_kind[2:0]
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [23:0]  cfg_wdata_i
);

  terq_pkg::terq_cmd_t  cmd;
  terq_pkg::terq_stat_t stat;

  logic [23:0] ms_per_sample_q;
  logic [9:0]  lookahead_q;
  logic [15:0] late_limit_q;
  logic [15:0] idle_wait_q;

  logic [2:0]  result_kind;
  logic [23:0] out_bytes;
  logic [1:0]  out_len;
  logic [31:0] release_ms;
  logic [31:0] wait_ms;
  logic [5:0]  queue_count;

  // Configuration registers; write them only while the block is idle, unchecked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_per_sample_q <= terq_pkg::MsPerSampleReset;
      lookahead_q     <= terq_pkg::LookaheadReset;
      late_limit_q    <= terq_pkg::LateLimitReset;
      idle_wait_q     <= terq_pkg::IdleWaitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        terq_pkg::CfgMsPerSample: ms_per_sample_q <= cfg_wdata_i;
        terq_pkg::CfgLookahead:   lookahead_q     <= cfg_wdata_i[9:0];
        terq_pkg::CfgLateLimit:   late_limit_q    <= cfg_wdata_i[15:0];
        terq_pkg::CfgIdleWait:    idle_wait_q     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  terq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (s_axis_tvalid && s_axis_tready),
    .out_fire_i  (m_axis_tvalid && m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid)
  );

  terq_datapath #(
    .QueueDepth (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_type_i       (s_axis_tuser),
    .block_start_ms_i (s_axis_tdata[31:0]),
    .sample_offset_i  (s_axis_tdata[47:32]),
    .msg_bytes_i      (s_axis_tdata[71:48]),
    .msg_len_i        (s_axis_tdata[73:72]),
    .now_ms_i         (s_axis_tdata[105:74]),
    .ms_per_sample_i  (ms_per_sample_q),
    .lookahead_i      (lookahead_q),
    .late_limit_i     (late_limit_q),
    .idle_wait_i      (idle_wait_q),
    .result_kind_o    (result_kind),
    .out_bytes_o      (out_bytes),
    .out_len_o        (out_len),
    .release_ms_o     (release_ms),
    .wait_ms_o        (wait_ms),
    .queue_count_o    (queue_count)
  );

  assign m_axis_tdata = {queue_count, wait_ms, release_ms, out_len, out_bytes};
  assign m_axis_tuser = result_kind;

endmodule

>>> bench/timed_event_release_queue_checker.sv
// Checker that predicts every result item of the release queue and compares it.
module timed_event_release_queue_checker #(
  parameter int unsigned QUEUE_DEPTH = terq_pkg::QueueDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [23:0]  cfg_wdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam logic [47:0] TimeSat = 48'hFFFF_FFFF_FFFF;

  logic [47:0] held_time[$];
  logic [25:0] held_msg[$];
  logic [23:0] ms_per_sample;
  logic [9:0]  lookahead;
  logic [15:0] late_limit;
  logic [15:0] idle_wait;
  logic [98:0] result_queue[$];

  function automatic logic [98:0] pack_result(logic [2:0] kind, logic [25:0] msg,
                                              logic [31:0] rel, logic [31:0] wt);
    logic [5:0] cnt;
    cnt = 6'(held_time.size());
    return {cnt, wt, rel, msg[25:24], msg[23:0], kind};
  endfunction

  task automatic queue_step(input logic [1:0] req, input logic [111:0] d);
    logic [63:0] t;
    logic [63:0] now, lim, rel;
    logic [25:0] msg;
    int pos;
    if (req == terq_pkg::ReqInsert) begin
      if (held_time.size() >= QUEUE_DEPTH) begin
        result_queue.push_back(pack_result(terq_pkg::KindFull, '0, '0, '0));
      end else begin
        t = ({32'd0, d[31:0]} << 16) + 64'(d[47:32]) * 64'(ms_per_sample);
        if (t > 64'(TimeSat)) t = 64'(TimeSat);
        pos = 0;
        while (pos < held_time.size() && 64'(held_time[pos]) <= t) pos++;
        held_time.insert(pos, t[47:0]);
        held_msg.insert(pos, {d[73:72], d[71:48]});
        result_queue.push_back(pack_result(terq_pkg::KindInserted, '0, '0, '0));
      end
    end else if (req == terq_pkg::ReqTick) begin
      now = 64'(d[105:74]);
      lim = now + 64'(lookahead);
      if (held_time.size() == 0) begin
        result_queue.push_back(pack_result(terq_pkg::KindNotDue, '0, '0, 32'(idle_wait)));
      end else begin
        rel = (64'(held_time[0]) + 64'h8000) >> 16;
        if (rel > 64'hFFFF_FFFF) rel = 64'hFFFF_FFFF;
        if (rel > lim) begin
          result_queue.push_back(pack_result(terq_pkg::KindNotDue, '0, '0,
                                             32'(rel - lim)));
        end else begin
          msg = held_msg.pop_front();
          void'(held_time.pop_front());
          result_queue.push_back(pack_result(
              (rel + 64'(late_limit) > now) ? terq_pkg::KindReleased
                                            : terq_pkg::KindDropped,
              msg, rel[31:0], '0));
        end
      end
    end else if (req == terq_pkg::ReqClear) begin
      held_time.delete();
      held_msg.delete();
      result_queue.push_back(pack_result(terq_pkg::KindCleared, '0, '0, '0));
    end
  endtask

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [98:0] e;
    if (!rst_ni) begin
      held_time.delete();
      held_msg.delete();
      result_queue.delete();
      ms_per_sample <= terq_pkg::MsPerSampleReset;
      lookahead <= terq_pkg::LookaheadReset;
      late_limit <= terq_pkg::LateLimitReset;
      idle_wait <= terq_pkg::IdleWaitReset;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          terq_pkg::CfgMsPerSample: ms_per_sample <= cfg_wdata_i;
          terq_pkg::CfgLookahead: lookahead <= cfg_wdata_i[9:0];
          terq_pkg::CfgLateLimit: late_limit <= cfg_wdata_i[15:0];
          terq_pkg::CfgIdleWait: idle_wait <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_queue.size() == 0) begin
          $error("Result item arrived with nothing expected");
          fail_count_o++;
        end else begin
          e = result_queue.pop_front();
          compare_field("result_kind", 64'(e[2:0]), 64'(m_axis_tuser));
          compare_field("out_bytes", 64'(e[26:3]), 64'(m_axis_tdata[23:0]));
          compare_field("out_len", 64'(e[28:27]), 64'(m_axis_tdata[25:24]));
          compare_field("release_ms", 64'(e[60:29]), 64'(m_axis_tdata[57:26]));
          compare_field("wait_ms", 64'(e[92:61]), 64'(m_axis_tdata[89:58]));
          compare_field("queue_count", 64'(e[98:93]), 64'(m_axis_tdata[95:90]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) queue_step(s_axis_tuser, s_axis_tdata);
      pending_o = result_queue.size();
    end
  end
endmodule

>>> bench/timed_event_release_queue_test.sv
// Top of the release queue testbench: clock, reset, stimulus and verdict.
module timed_event_release_queue_test;

  localparam int Depth = 32;
  localparam int IdleLimit = 20000;
  // Request code that the block ignores.
  localparam logic [1:0] ReqUnknown = 2'd3;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = terq_pkg::ReqInsert;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_index_i = terq_pkg::CfgMsPerSample;
  logic [23:0]  cfg_wdata_i = '0;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  // Set while the receiver is asked to hold off for a long stretch.
  logic         hold_request = 1'b0;
  // Base time around which random inserts and ticks are placed, so that
  // ticks land near the held entries and both release and drop happen.
  logic [31:0]  base_ms = 32'd100000;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  timed_event_release_queue #(.QUEUE_DEPTH(Depth)) dut (.*);

  timed_event_release_queue_checker #(.QUEUE_DEPTH(Depth)) checker_inst (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .cfg_we_i,
    .cfg_index_i, .cfg_wdata_i, .fail_count_o(fail_count), .pending_o(pending));

  // The receiver stalls on its own random pattern, sometimes running freely,
  // and once holds off for a long stretch so that the queue backs up.
  initial begin : receiver
    int mode;
    int span;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (3000) @(negedge clk_i);
        hold_request = 1'b0;
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(1, 40);
      repeat (span) begin
        @(negedge clk_i);
        m_axis_tready <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(0, 3) != 0)
                                                         : ($urandom_range(0, 1) == 1);
      end
    end
  end

  // A watchdog ends the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_request)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timed_event_release_queue test failed");
      $finish;
    end
  end

  // Offers one item and waits until it is taken; the valid stays high when
  // the next item follows at once.
  task automatic send_item(input logic [1:0] req, input logic [111:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  function automatic logic [111:0] insert_data(logic [31:0] start, logic [15:0] offs,
                                               logic [23:0] bytes, logic [1:0] len);
    return {6'd0, 32'd0, len, bytes, offs, start};
  endfunction

  // The insert fields of a tick carry noise that the block must ignore.
  function automatic logic [111:0] tick_data(logic [31:0] now);
    return {6'd0, now, 2'($urandom), 24'($urandom), 16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [111:0] rand_data();
    return {16'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
  endfunction

  // Pauses until every expected result is back and the block is quiet.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      send_item(terq_pkg::ReqInsert,
                insert_data(base_ms + $urandom_range(0, 300), 16'($urandom),
                            24'($urandom), 2'($urandom)));
    else if (pick < 90)
      send_item(terq_pkg::ReqTick, tick_data(base_ms + $urandom_range(0, 900)));
    else if (pick < 93)
      send_item(terq_pkg::ReqClear, rand_data());
    else if (pick < 96)
      send_item(ReqUnknown, rand_data());
    else
      send_item(2'($urandom_range(0, 2)), rand_data());
  endtask

  initial begin : stimulus
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part with reset settings: empty tick, extremes of every field,
    // equal times kept in order, a time that saturates, release and drop,
    // an unknown request and a clear.
    send_item(terq_pkg::ReqTick, tick_data(32'd0));
    send_item(terq_pkg::ReqInsert, insert_data(32'd1000, 16'd0, 24'hABCDEF, 2'd3));
    send_item(terq_pkg::ReqInsert, insert_data(32'd1000, 16'd0, 24'h123456, 2'd1));
    send_item(terq_pkg::ReqInsert, insert_data(32'hFFFF_FFFF, 16'hFFFF, 24'hFFFFFF, 2'd2));
    send_item(terq_pkg::ReqInsert, insert_data(32'd0, 16'd0, 24'd0, 2'd0));
    send_item(terq_pkg::ReqTick, tick_data(32'd0));
    send_item(terq_pkg::ReqTick, tick_data(32'd500));
    send_item(terq_pkg::ReqTick, tick_data(32'd1300));
    send_item(terq_pkg::ReqTick, tick_data(32'd990));
    send_item(terq_pkg::ReqTick, tick_data(32'hFFFF_FFFF));
    send_item(ReqUnknown, {112{1'b1}});
    send_item(terq_pkg::ReqInsert, insert_data(32'd5, 16'd100, 24'h800000, 2'd1));
    send_item(terq_pkg::ReqClear, '0);
    send_item(terq_pkg::ReqTick, tick_data(32'd7));
    drain();

    // Extreme settings, then fill past full while the receiver holds off.
    write_reg(terq_pkg::CfgMsPerSample, 24'hFFFFFF);
    write_reg(terq_pkg::CfgLookahead, 24'd1000);
    write_reg(terq_pkg::CfgLateLimit, 24'd65535);
    write_reg(terq_pkg::CfgIdleWait, 24'd65535);
    send_item(terq_pkg::ReqTick, tick_data(32'd3));
    hold_request = 1'b1;
    repeat (Depth + 3)
      send_item(terq_pkg::ReqInsert, insert_data(32'($urandom), 16'($urandom),
                                                 24'($urandom), 2'($urandom)));
    repeat (Depth + 2) send_item(terq_pkg::ReqTick, tick_data(32'hFFFF_FFFF));
    drain();

    write_reg(terq_pkg::CfgMsPerSample, 24'd1);
    write_reg(terq_pkg::CfgLookahead, 24'd0);
    write_reg(terq_pkg::CfgLateLimit, 24'd0);
    write_reg(terq_pkg::CfgIdleWait, 24'd0);
    send_item(terq_pkg::ReqTick, tick_data(32'd9));
    send_item(terq_pkg::ReqInsert, insert_data(32'd50, 16'hFFFF, 24'h55AA55, 2'd3));
    send_item(terq_pkg::ReqTick, tick_data(32'd50));
    send_item(terq_pkg::ReqTick, tick_data(32'd51));
    drain();

    // Random part in phases with different settings.
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(terq_pkg::CfgMsPerSample,
                (phase == 0) ? terq_pkg::MsPerSampleReset : 24'($urandom_range(1, 6000)));
      write_reg(terq_pkg::CfgLookahead, 24'($urandom_range(0, 1000)));
      write_reg(terq_pkg::CfgLateLimit, 24'($urandom_range(0, 400)));
      write_reg(terq_pkg::CfgIdleWait, 24'($urandom));
      repeat (85) begin
        random_item();
        if ($urandom_range(0, 40) == 0) base_ms = base_ms + $urandom_range(0, 600);
      end
      drain();
    end

    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("timed_event_release_queue test passed");
    else
      $display("timed_event_release_queue test failed");
    $finish;
  end
endmodule
